/* sv/hat_pkg.sv */
package hat_pkg;

  // default sample width, signed Q16.16
  localparam int unsigned VALUE_BITS_DEF = 32;

  // configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HH_LIMIT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_LIMIT      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L_LIMIT      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LL_LIMIT     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEV_TABLE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_ACTIONS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_OUTPUTS = 4'd7;

  // field widths of the fixed-size registers
  localparam int unsigned HYST_W    = 31;
  localparam int unsigned SEV_ENT_W = 11;
  localparam int unsigned SEV_NUM   = 5;
  localparam int unsigned SEV_TBL_W = SEV_ENT_W * SEV_NUM;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned SAFE_W    = 32;
  localparam int unsigned SEV_W     = 10;

  // severity table slots
  localparam logic [2:0] SEV_SEL_NORMAL = 3'd0;
  localparam logic [2:0] SEV_SEL_HH     = 3'd1;
  localparam logic [2:0] SEV_SEL_LL     = 3'd2;
  localparam logic [2:0] SEV_SEL_H      = 3'd3;
  localparam logic [2:0] SEV_SEL_L      = 3'd4;

  localparam logic [SEV_ENT_W-1:0] SEV_MAX = 11'd1000;
  localparam logic [SEV_ENT_W-1:0] SEV_MIN = 11'd1;

  // trip action codes, the fourth code behaves as hold
  localparam logic [ACT_W-1:0] ACT_HOLD     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MANUAL   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SAFE     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_HOLD_ALT = 2'd3;

  typedef struct packed {
    logic hh;
    logic h;
    logic l;
    logic ll;
  } hat_flags_t;

  typedef struct packed {
    logic [HYST_W-1:0]    hyst_band;
    logic [SEV_TBL_W-1:0] sev_table;
    logic [2*ACT_W-1:0]   trip_actions;
    logic [2*SAFE_W-1:0]  safe_outputs;
  } hat_ctl_t;

endpackage

/* sv/hat_in_if.sv */
interface hat_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] process_value;
  logic signed [VALUE_BITS-1:0] controller_output;
  logic signed [VALUE_BITS-1:0] manual_output;

  modport source (output valid, process_value, controller_output, manual_output,
                  input ready);
  modport sink (input valid, process_value, controller_output, manual_output,
                output ready);
endinterface

/* sv/hat_out_if.sv */
interface hat_out_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         hh_active;
  logic                         h_active;
  logic                         l_active;
  logic                         ll_active;
  logic                         any_active;
  logic                         flags_changed;
  logic [9:0]                   severity;
  logic signed [VALUE_BITS-1:0] drive_out;
  logic                         force_manual;

  modport source (output valid, hh_active, h_active, l_active, ll_active, any_active,
                  flags_changed, severity, drive_out, force_manual,
                  input ready);
  modport sink (input valid, hh_active, h_active, l_active, ll_active, any_active,
                flags_changed, severity, drive_out, force_manual,
                output ready);
endinterface

/* sv/hat_cfg_regs.sv */
module hat_cfg_regs #(
  parameter int unsigned VALUE_BITS = hat_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hat_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic signed [VALUE_BITS-1:0]      hh_limit,
  output logic signed [VALUE_BITS-1:0]      h_limit,
  output logic signed [VALUE_BITS-1:0]      l_limit,
  output logic signed [VALUE_BITS-1:0]      ll_limit,
  output hat_pkg::hat_ctl_t                 ctl
);
  import hat_pkg::*;

  localparam logic [VALUE_BITS-1:0] LIM_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] LIM_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] hh_limit_r, h_limit_r, l_limit_r, ll_limit_r;
  hat_ctl_t              ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hh_limit_r         <= LIM_MAX;
      h_limit_r          <= LIM_MAX;
      l_limit_r          <= LIM_MIN;
      ll_limit_r         <= LIM_MIN;
      ctl_r.hyst_band    <= '0;
      ctl_r.sev_table    <= SEV_TBL_W'(1);
      ctl_r.trip_actions <= '0;
      ctl_r.safe_outputs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HH_LIMIT:     hh_limit_r         <= cfg_wdata[VALUE_BITS-1:0];
        REG_H_LIMIT:      h_limit_r          <= cfg_wdata[VALUE_BITS-1:0];
        REG_L_LIMIT:      l_limit_r          <= cfg_wdata[VALUE_BITS-1:0];
        REG_LL_LIMIT:     ll_limit_r         <= cfg_wdata[VALUE_BITS-1:0];
        REG_HYST_BAND:    ctl_r.hyst_band    <= cfg_wdata[HYST_W-1:0];
        REG_SEV_TABLE:    ctl_r.sev_table    <= cfg_wdata[SEV_TBL_W-1:0];
        REG_TRIP_ACTIONS: ctl_r.trip_actions <= cfg_wdata[2*ACT_W-1:0];
        REG_SAFE_OUTPUTS: ctl_r.safe_outputs <= cfg_wdata[2*SAFE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign hh_limit = hh_limit_r;
  assign h_limit  = h_limit_r;
  assign l_limit  = l_limit_r;
  assign ll_limit = ll_limit_r;
  assign ctl      = ctl_r;

endmodule

/* sv/hat_eval.sv */
module hat_eval #(
  parameter int unsigned VALUE_BITS = hat_pkg::VALUE_BITS_DEF
) (
  input  hat_pkg::hat_flags_t            flags,
  input  logic signed [VALUE_BITS-1:0]   hh_limit,
  input  logic signed [VALUE_BITS-1:0]   h_limit,
  input  logic signed [VALUE_BITS-1:0]   l_limit,
  input  logic signed [VALUE_BITS-1:0]   ll_limit,
  input  hat_pkg::hat_ctl_t              ctl,
  input  logic signed [VALUE_BITS-1:0]   process_value,
  input  logic signed [VALUE_BITS-1:0]   controller_output,
  input  logic signed [VALUE_BITS-1:0]   manual_output,
  output hat_pkg::hat_flags_t            flags_nxt,
  output logic [hat_pkg::SEV_W-1:0]      severity,
  output logic signed [VALUE_BITS-1:0]   drive_out,
  output logic                           force_manual
);
  import hat_pkg::*;

  // wide enough that limit -/+ band never wraps
  localparam int unsigned CMP_W  = ((VALUE_BITS > HYST_W) ? VALUE_BITS : HYST_W + 1) + 1;
  localparam int unsigned SAFE_B = (VALUE_BITS > SAFE_W) ? SAFE_W : VALUE_BITS;

  logic signed [CMP_W-1:0]  pv_w, hyst_w;
  logic signed [CMP_W-1:0]  hh_w, h_w, l_w, ll_w;
  logic signed [SAFE_B-1:0] safe_hh, safe_ll;
  logic [2:0]               sel;
  logic [SEV_ENT_W-1:0]     sev_raw, sev_clip;
  logic [ACT_W-1:0]         act;
  logic                     trip;
  logic signed [VALUE_BITS-1:0] safe_sel;

  always_comb begin
    pv_w   = CMP_W'(process_value);
    hyst_w = CMP_W'(signed'({1'b0, ctl.hyst_band}));
    hh_w   = CMP_W'(hh_limit);
    h_w    = CMP_W'(h_limit);
    l_w    = CMP_W'(l_limit);
    ll_w   = CMP_W'(ll_limit);

    // set at the limit, clear once past it by the band
    flags_nxt.hh = flags.hh ? !(pv_w <= hh_w - hyst_w) : (pv_w >= hh_w);
    flags_nxt.h  = flags.h  ? !(pv_w <= h_w  - hyst_w) : (pv_w >= h_w);
    flags_nxt.ll = flags.ll ? !(pv_w >= ll_w + hyst_w) : (pv_w <= ll_w);
    flags_nxt.l  = flags.l  ? !(pv_w >= l_w  + hyst_w) : (pv_w <= l_w);
  end

  // severity in priority order hh, ll, h, l, normal
  always_comb begin
    if (flags_nxt.hh)      sel = SEV_SEL_HH;
    else if (flags_nxt.ll) sel = SEV_SEL_LL;
    else if (flags_nxt.h)  sel = SEV_SEL_H;
    else if (flags_nxt.l)  sel = SEV_SEL_L;
    else                   sel = SEV_SEL_NORMAL;

    sev_raw = ctl.sev_table[sel*SEV_ENT_W +: SEV_ENT_W];
    if (sev_raw > SEV_MAX)       sev_clip = SEV_MAX;
    else if (sev_raw <= SEV_MIN) sev_clip = SEV_MIN;
    else                         sev_clip = sev_raw;
    severity = sev_clip[SEV_W-1:0];
  end

  // trip override, hh takes precedence over ll
  always_comb begin
    safe_hh  = ctl.safe_outputs[SAFE_B-1:0];
    safe_ll  = ctl.safe_outputs[SAFE_W +: SAFE_B];
    trip     = flags_nxt.hh || flags_nxt.ll;
    act      = flags_nxt.hh ? ctl.trip_actions[ACT_W-1:0]
                            : ctl.trip_actions[2*ACT_W-1:ACT_W];
    safe_sel = flags_nxt.hh ? VALUE_BITS'(safe_hh) : VALUE_BITS'(safe_ll);

    drive_out    = controller_output;
    force_manual = 1'b0;
    if (trip) begin
      case (act)
        ACT_MANUAL: begin
          drive_out    = manual_output;
          force_manual = 1'b1;
        end
        ACT_SAFE: drive_out = safe_sel;
        default:  drive_out = controller_output;
      endcase
    end
  end

endmodule

/* sv/hysteresis_alarm_trip_unit.sv */
// an accepted input beat moves through the input stage and the result register to out_if
// throughput: one beat per cycle while out_if.ready holds; the alarm flags close their loop
//   through flags_r, between the input stage and the result register
// reset (rst_n low, synchronous): flags cleared, both stages emptied, limits to
//   their extremes, band/actions/safe outputs to zero, severity table normal entry one, rest zero
module hysteresis_alarm_trip_unit #(
  parameter int unsigned VALUE_BITS = hat_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hat_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  hat_in_if.sink                          in_if,
  hat_out_if.source                       out_if
);
  import hat_pkg::*;

  // configuration
  logic signed [VALUE_BITS-1:0] hh_limit, h_limit, l_limit, ll_limit;
  hat_ctl_t                     ctl;

  hat_cfg_regs #(.VALUE_BITS(VALUE_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .hh_limit  (hh_limit),
    .h_limit   (h_limit),
    .l_limit   (l_limit),
    .ll_limit  (ll_limit),
    .ctl       (ctl)
  );

  // input stage: holds one beat until the result register can take it
  logic                         s1_valid_r, s1_valid_nxt;
  logic signed [VALUE_BITS-1:0] s1_pv_r, s1_co_r, s1_mo_r;

  // alarm state and result register
  hat_flags_t                   flags_r, flags_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_changed_r;
  logic [SEV_W-1:0]             out_sev_r;
  logic signed [VALUE_BITS-1:0] out_drive_r;
  logic                         out_man_r;

  logic                         in_take;   // input beat accepted
  logic                         advance;   // input stage moves into result register

  logic [SEV_W-1:0]             sev_c;
  logic signed [VALUE_BITS-1:0] drive_c;
  logic                         man_c;

  // result register is free when empty or being drained this cycle
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)           out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
  end

  // flag update, severity pick and drive override for the staged beat
  hat_eval #(.VALUE_BITS(VALUE_BITS)) u_eval (
    .flags             (flags_r),
    .hh_limit          (hh_limit),
    .h_limit           (h_limit),
    .l_limit           (l_limit),
    .ll_limit          (ll_limit),
    .ctl               (ctl),
    .process_value     (s1_pv_r),
    .controller_output (s1_co_r),
    .manual_output     (s1_mo_r),
    .flags_nxt         (flags_nxt),
    .severity          (sev_c),
    .drive_out         (drive_c),
    .force_manual      (man_c)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // flags move only with a beat, so each sample sees its predecessor's state
      if (advance) flags_r <= flags_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pv_r <= in_if.process_value;
      s1_co_r <= in_if.controller_output;
      s1_mo_r <= in_if.manual_output;
    end
    if (advance) begin
      out_changed_r <= (flags_nxt != flags_r);
      out_sev_r     <= sev_c;
      out_drive_r   <= drive_c;
      out_man_r     <= man_c;
    end
  end

  // the result flags are the live state: both load on the same beat
  assign out_if.valid         = out_valid_r;
  assign out_if.hh_active     = flags_r.hh;
  assign out_if.h_active      = flags_r.h;
  assign out_if.l_active      = flags_r.l;
  assign out_if.ll_active     = flags_r.ll;
  assign out_if.any_active    = |flags_r;
  assign out_if.flags_changed = out_changed_r;
  assign out_if.severity      = out_sev_r;
  assign out_if.drive_out     = out_drive_r;
  assign out_if.force_manual  = out_man_r;

  // alarm state holds between beats
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flags_r))
    else $error("alarm flags changed without a beat");

  // severity always within the clamp window
  a_sev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.severity >= 10'd1 && out_if.severity <= 10'd1000))
    else $error("severity outside clamp range");

  // manual override only on a high-high or low-low trip
  a_man_trip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.force_manual) |-> (out_if.hh_active || out_if.ll_active))
    else $error("manual override without trip");

  // a result with no change reports the same flags as the previous result
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_changed_r == (flags_r != $past(flags_r))))
    else $error("changed flag does not match flag update");

  // the input stage never drops a beat while the result register is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted into an occupied stage");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import hat_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int Q1              = 65536;   // 1.0 in Q16.16

  localparam logic [31:0] LEVEL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] LEVEL_MIN = 32'h8000_0000;

  // indexes past the end of the register map, writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  // normal 0, HH 2047, LL 1000, H 1001, L 1, junk above the table
  localparam logic [CFG_DATA_W-1:0] DIR_SEV_TABLE =
    (64'd2047 << (SEV_ENT_W * SEV_SEL_HH)) | (64'd1000 << (SEV_ENT_W * SEV_SEL_LL)) |
    (64'd1001 << (SEV_ENT_W * SEV_SEL_H)) | (64'd1 << (SEV_ENT_W * SEV_SEL_L)) |
    64'hFF80_0000_0000_0000;

  typedef enum {PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;
  typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic             hh;
    logic             h;
    logic             l;
    logic             ll;
    logic             any_on;
    logic             chg;
    logic [SEV_W-1:0] sev;
    logic [31:0]      drive;
    logic             man;
  } alarm_result_t;

  typedef struct {
    bit            typed;
    alarm_result_t want;
  } sample_note_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [31:0]           pv;
    logic [31:0]           co;
    logic [31:0]           mo;
    bit                    typed;
    alarm_result_t         want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hat_in_if  #(.VALUE_BITS(VALUE_BITS_DEF)) in_ch ();
  hat_out_if #(.VALUE_BITS(VALUE_BITS_DEF)) out_ch ();

  hysteresis_alarm_trip_unit #(.VALUE_BITS(VALUE_BITS_DEF)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always #4 clk = ~clk;

  // mirror of the alarm state and the register file
  hat_flags_t           alarm_flags;
  logic [31:0]          sh_hh, sh_h, sh_l, sh_ll;
  logic [HYST_W-1:0]    sh_band;
  logic [SEV_TBL_W-1:0] sh_sev;
  logic [2*ACT_W-1:0]   sh_act;
  logic [2*SAFE_W-1:0]  sh_safe;

  alarm_result_t pending_results[$];   // predicted result beats, oldest first
  sample_note_t  sent_notes[$];        // typed-in answers for beats on their way in
  stim_row_t     rows[$];
  logic [63:0]   phase_cfg [8];        // register values of the current random phase
  pace_t         pace = PACE_FREE;
  int            mismatches = 0;
  int            cycle_count = 0;

  // one sample through the four comparators, severity pick and trip override
  function automatic alarm_result_t predict_alarm(logic [31:0] pv_in, co_in, mo_in);
    longint        pv, band, lhh, lh, lo, llo;
    hat_flags_t    prev;
    alarm_result_t r;
    logic [2:0]    sel;
    logic [10:0]   ent;
    logic [1:0]    act;
    pv   = longint'($signed(pv_in));
    band = longint'(sh_band);
    lhh  = longint'($signed(sh_hh));
    lh   = longint'($signed(sh_h));
    lo   = longint'($signed(sh_l));
    llo  = longint'($signed(sh_ll));
    prev = alarm_flags;
    // 64-bit compare, so limit -/+ band never wraps
    if (!alarm_flags.hh) begin
      if (pv >= lhh) alarm_flags.hh = 1'b1;
    end else if (pv <= lhh - band) begin
      alarm_flags.hh = 1'b0;
    end
    if (!alarm_flags.h) begin
      if (pv >= lh) alarm_flags.h = 1'b1;
    end else if (pv <= lh - band) begin
      alarm_flags.h = 1'b0;
    end
    if (!alarm_flags.ll) begin
      if (pv <= llo) alarm_flags.ll = 1'b1;
    end else if (pv >= llo + band) begin
      alarm_flags.ll = 1'b0;
    end
    if (!alarm_flags.l) begin
      if (pv <= lo) alarm_flags.l = 1'b1;
    end else if (pv >= lo + band) begin
      alarm_flags.l = 1'b0;
    end
    r.hh     = alarm_flags.hh;
    r.h      = alarm_flags.h;
    r.l      = alarm_flags.l;
    r.ll     = alarm_flags.ll;
    r.any_on = |alarm_flags;
    r.chg    = (prev != alarm_flags);
    // priority hh, ll, h, l, normal
    if (alarm_flags.hh) sel = SEV_SEL_HH;
    else if (alarm_flags.ll) sel = SEV_SEL_LL;
    else if (alarm_flags.h) sel = SEV_SEL_H;
    else if (alarm_flags.l) sel = SEV_SEL_L;
    else sel = SEV_SEL_NORMAL;
    ent = sh_sev[sel * SEV_ENT_W +: SEV_ENT_W];
    if (ent > SEV_MAX) ent = SEV_MAX;
    if (ent <= SEV_MIN) ent = SEV_MIN;
    r.sev   = ent[SEV_W-1:0];
    // override: hh action wins when both trips are up
    r.drive = co_in;
    r.man   = 1'b0;
    act     = ACT_HOLD;
    if (alarm_flags.hh) act = sh_act[ACT_W-1:0];
    else if (alarm_flags.ll) act = sh_act[2*ACT_W-1:ACT_W];
    if (alarm_flags.hh || alarm_flags.ll) begin
      if (act == ACT_MANUAL) begin
        r.drive = mo_in;
        r.man   = 1'b1;
      end else if (act == ACT_SAFE) begin
        r.drive = alarm_flags.hh ? sh_safe[SAFE_W-1:0] : sh_safe[2*SAFE_W-1:SAFE_W];
      end
    end
    return r;
  endfunction

  function automatic alarm_result_t outcome(bit hh, h, l, ll, chg, logic [SEV_W-1:0] sev,
                                            logic [31:0] drive, bit man);
    alarm_result_t r;
    r = {hh, h, l, ll, hh | h | l | ll, chg, sev, drive, man};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    r.pv    = '0;
    r.co    = '0;
    r.mo    = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t sample_row(logic [31:0] pv, co, mo, bit typed = 1'b0,
                                           alarm_result_t want = '0);
    stim_row_t r;
    r.kind  = ROW_SAMPLE;
    r.idx   = '0;
    r.data  = '0;
    r.pv    = pv;
    r.co    = co;
    r.mo    = mo;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic bit roll_idle(bit sender);
    int pct;
    pct = 0;
    if (pace == PACE_BOTH) pct = 6;
    else if (sender ? (pace == PACE_SRC_IDLE) : (pace == PACE_SINK_STALL)) pct = 61;
    return $urandom_range(0, 99) < pct;
  endfunction

  // register values for one random phase: extremes, reversed, ordered or wild
  function automatic void plan_phase(int k);
    longint               base, step;
    logic [31:0]          lim [4];
    logic [31:0]          band;
    logic [SEV_TBL_W-1:0] sev;
    logic [10:0]          ent;
    case (k)
      0: begin
        lim  = '{LEVEL_MAX, LEVEL_MAX, LEVEL_MIN, LEVEL_MIN};
        band = 32'h0;
      end
      1: begin
        // every trip level sits on the wrong side, all four alarms stick
        lim  = '{LEVEL_MIN, LEVEL_MIN, LEVEL_MAX, LEVEL_MAX};
        band = 32'hFFFF_FFFF;
      end
      PHASES - 1: begin
        lim  = '{LEVEL_MAX, LEVEL_MAX, LEVEL_MIN, LEVEL_MIN};
        band = 32'hFFFF_FFFF;
      end
      PHASES - 2: begin
        lim  = '{$urandom, $urandom, $urandom, $urandom};
        band = $urandom;
      end
      default: begin
        // hh > h > l > ll spaced evenly around a center
        base = longint'($urandom_range(0, 32'h3FFF_FFFF)) - longint'(32'h2000_0000);
        step = ($urandom_range(0, 1) != 0) ? longint'($urandom_range(1, 256))
                                            : longint'($urandom_range(1, 32'h0100_0000));
        lim  = '{32'(base + 2 * step), 32'(base + step), 32'(base - step),
                 32'(base - 2 * step)};
        band = $urandom_range(0, 32'(step));
      end
    endcase
    for (int s = 0; s < SEV_NUM; s++) begin
      case ($urandom_range(0, 7))
        0: ent = 11'd0;
        1: ent = 11'd1;
        2: ent = 11'd2;
        3: ent = 11'd999;
        4: ent = 11'd1000;
        5: ent = 11'd1001;
        6: ent = 11'd2047;
        default: ent = 11'($urandom);
      endcase
      sev[s * SEV_ENT_W +: SEV_ENT_W] = ent;
    end
    // upper bits carry junk that the block has to drop
    phase_cfg[REG_HH_LIMIT]     = {$urandom, lim[0]};
    phase_cfg[REG_H_LIMIT]      = {$urandom, lim[1]};
    phase_cfg[REG_L_LIMIT]      = {$urandom, lim[2]};
    phase_cfg[REG_LL_LIMIT]     = {$urandom, lim[3]};
    phase_cfg[REG_HYST_BAND]    = {$urandom, band};
    phase_cfg[REG_SEV_TABLE]    = {9'($urandom), sev};
    phase_cfg[REG_TRIP_ACTIONS] = {$urandom, $urandom};
    phase_cfg[REG_SAFE_OUTPUTS] = {$urandom, $urandom};
  endfunction

  // process value aimed at a trip level, its clear point or nearby, some noise
  function automatic logic [31:0] pick_level();
    longint lim, band, span, v;
    int     r;
    r    = $urandom_range(0, 99);
    lim  = longint'($signed(phase_cfg[$urandom_range(REG_HH_LIMIT, REG_LL_LIMIT)][31:0]));
    band = longint'(phase_cfg[REG_HYST_BAND][HYST_W-1:0]);
    if (r < 10) return $urandom;
    if (r < 35) begin
      case ($urandom_range(0, 4))
        0: v = lim;
        1: v = lim - band;
        2: v = lim + band;
        3: v = lim - 1;
        default: v = lim + 1;
      endcase
    end else begin
      span = band + 64;
      v    = lim + longint'({$urandom, $urandom} % (2 * span + 1)) - span;
    end
    if (v > longint'($signed(LEVEL_MAX))) v = longint'($signed(LEVEL_MAX));
    if (v < longint'($signed(LEVEL_MIN))) v = longint'($signed(LEVEL_MIN));
    return v[31:0];
  endfunction

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // one input beat, with random gaps ahead of it; returns once accepted
  task automatic send_sample(logic [31:0] pv, co, mo, bit typed, alarm_result_t want);
    sample_note_t note;
    note.typed = typed;
    note.want  = want;
    while (roll_idle(1'b1)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sent_notes.push_back(note);
    in_ch.valid             <= 1'b1;
    in_ch.process_value     <= pv;
    in_ch.controller_output <= co;
    in_ch.manual_output     <= mo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain every pending beat, then let the two pipeline stages empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || sent_notes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // receiver back pressure
  always @(negedge clk) out_ch.ready <= !roll_idle(1'b0);

  // register writes and accepted input beats feed the predictor
  always @(posedge clk) begin : track_inputs
    sample_note_t  note;
    alarm_result_t guess;
    if (!rst_n) begin
      alarm_flags = '0;
      sh_hh       = LEVEL_MAX;
      sh_h        = LEVEL_MAX;
      sh_l        = LEVEL_MIN;
      sh_ll       = LEVEL_MIN;
      sh_band     = '0;
      sh_sev      = SEV_TBL_W'(1);
      sh_act      = '0;
      sh_safe     = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HH_LIMIT:     sh_hh   = cfg_wdata[31:0];
          REG_H_LIMIT:      sh_h    = cfg_wdata[31:0];
          REG_L_LIMIT:      sh_l    = cfg_wdata[31:0];
          REG_LL_LIMIT:     sh_ll   = cfg_wdata[31:0];
          REG_HYST_BAND:    sh_band = cfg_wdata[HYST_W-1:0];
          REG_SEV_TABLE:    sh_sev  = cfg_wdata[SEV_TBL_W-1:0];
          REG_TRIP_ACTIONS: sh_act  = cfg_wdata[2*ACT_W-1:0];
          REG_SAFE_OUTPUTS: sh_safe = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        guess = predict_alarm(in_ch.process_value, in_ch.controller_output,
                              in_ch.manual_output);
        note  = sent_notes.pop_front();
        // typed-in rows stand on their own, the predictor still tracks the flags
        pending_results.push_back(note.typed ? note.want : guess);
      end
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk) begin : check_results
    alarm_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.hh_active, out_ch.h_active, out_ch.l_active, out_ch.ll_active,
             out_ch.any_active, out_ch.flags_changed, out_ch.severity, out_ch.drive_out,
             out_ch.force_manual};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending, expected none, got %0h",
                 $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("hh_active", want.hh, got.hh);
        check_field("h_active", want.h, got.h);
        check_field("l_active", want.l, got.l);
        check_field("ll_active", want.ll, got.ll);
        check_field("any_active", want.any_on, got.any_on);
        check_field("flags_changed", want.chg, got.chg);
        check_field("severity", want.sev, got.sev);
        check_field("drive_out", want.drive, got.drive);
        check_field("force_manual", want.man, got.man);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit writing;
    writing                  = 1'b0;
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_wdata                = '0;
    in_ch.valid              = 1'b0;
    in_ch.process_value      = '0;
    in_ch.controller_output  = '0;
    in_ch.manual_output      = '0;
    out_ch.ready             = 1'b0;

    // directed rows, reset config first: levels at the extremes, band zero
    rows.push_back(sample_row(32'd0, 32'h1234_5678, 32'h0BAD_F00D, 1'b1,
                              outcome(0, 0, 0, 0, 0, 10'd1, 32'h1234_5678, 0)));
    // full-scale high reaches the max-positive levels, zero table entry gives one
    rows.push_back(sample_row(LEVEL_MAX, LEVEL_MIN, LEVEL_MAX, 1'b1,
                              outcome(1, 1, 0, 0, 1, 10'd1, LEVEL_MIN, 0)));
    rows.push_back(sample_row(LEVEL_MIN, LEVEL_MAX, 32'd0, 1'b1,
                              outcome(0, 0, 1, 1, 1, 10'd1, LEVEL_MAX, 0)));
    rows.push_back(sample_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b1,
                              outcome(0, 0, 0, 0, 1, 10'd1, 32'hFFFF_FFFF, 0)));
    // realistic levels, junk above the table, actions, hh, h and band, spare indexes written
    rows.push_back(reg_row(REG_SEV_TABLE, DIR_SEV_TABLE));
    rows.push_back(reg_row(REG_TRIP_ACTIONS, 64'hFFF0 | {ACT_SAFE, ACT_MANUAL}));
    rows.push_back(reg_row(REG_SAFE_OUTPUTS, {LEVEL_MAX, LEVEL_MIN}));
    rows.push_back(reg_row(REG_HH_LIMIT, {32'hDEAD_BEEF, 32'(100 * Q1)}));
    rows.push_back(reg_row(REG_H_LIMIT, {32'hFFFF_FFFF, 32'(50 * Q1)}));
    rows.push_back(reg_row(REG_L_LIMIT, {32'h0, 32'(-50 * Q1)}));
    rows.push_back(reg_row(REG_LL_LIMIT, {32'h0, 32'(-100 * Q1)}));
    rows.push_back(reg_row(REG_HYST_BAND, 64'hFFFF_FFFF_8000_0000 | 64'(10 * Q1)));
    rows.push_back(reg_row(REG_SPARE_LO, '1));
    rows.push_back(reg_row(REG_SPARE_HI, '1));
    rows.push_back(sample_row(32'd0, 32'h0000_1111, 32'h2222_0000, 1'b1,
                              outcome(0, 0, 0, 0, 0, 10'd1, 32'h0000_1111, 0)));
    // hh trip to manual, table entry above the cap
    rows.push_back(sample_row(32'(100 * Q1), 32'h3333_0000, 32'hCCCC_0000, 1'b1,
                              outcome(1, 1, 0, 0, 1, 10'd1000, 32'hCCCC_0000, 1)));
    // inside the band, at the clear point, at the h clear point
    rows.push_back(sample_row(32'(95 * Q1), $urandom, $urandom));
    rows.push_back(sample_row(32'(90 * Q1), $urandom, $urandom));
    rows.push_back(sample_row(32'(40 * Q1), $urandom, $urandom));
    // ll trip to the safe output
    rows.push_back(sample_row(32'(-100 * Q1), 32'h0101_0101, 32'h0202_0202, 1'b1,
                              outcome(0, 0, 1, 1, 1, 10'd1000, LEVEL_MAX, 0)));
    rows.push_back(sample_row(32'(-91 * Q1), $urandom, $urandom));
    rows.push_back(sample_row(32'(-90 * Q1), $urandom, $urandom));
    // fourth action code behaves as hold
    rows.push_back(reg_row(REG_TRIP_ACTIONS, {ACT_HOLD_ALT, ACT_HOLD_ALT}));
    rows.push_back(sample_row(32'(-100 * Q1), $urandom, $urandom));
    rows.push_back(sample_row(LEVEL_MAX, $urandom, $urandom));
    // hh and ll on the same level so both trip together, hh action wins
    rows.push_back(reg_row(REG_HH_LIMIT, 64'd0));
    rows.push_back(reg_row(REG_LL_LIMIT, 64'd0));
    rows.push_back(reg_row(REG_HYST_BAND, 64'(Q1)));
    rows.push_back(reg_row(REG_TRIP_ACTIONS, {ACT_MANUAL, ACT_SAFE}));
    rows.push_back(sample_row(32'd0, $urandom, $urandom));
    rows.push_back(sample_row(32'(-Q1), $urandom, $urandom));
    rows.push_back(sample_row(LEVEL_MIN, $urandom, $urandom));
    rows.push_back(sample_row(LEVEL_MAX, $urandom, $urandom));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        // registers only change with the pipeline empty
        if (!writing) begin
          settle();
          writing = 1'b1;
        end
        apply_reg(rows[i].idx, rows[i].data);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_sample(rows[i].pv, rows[i].co, rows[i].mo, rows[i].typed, rows[i].want);
      end
    end

    // random phases, each with a fresh register set and one of four idling patterns
    for (int k = 0; k < PHASES; k++) begin
      settle();
      plan_phase(k);
      pace = pace_t'(k % 4);
      for (int r = REG_HH_LIMIT; r <= REG_SAFE_OUTPUTS; r++)
        apply_reg(CFG_IDX_W'(r), phase_cfg[r]);
      cfg_we <= 1'b0;
      repeat (ITEMS_PER_PHASE) send_sample(pick_level(), $urandom, $urandom, 1'b0, '0);
    end

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* hysteresis_alarm_trip_unit.f */
sv/hat_pkg.sv
sv/hat_in_if.sv
sv/hat_out_if.sv
sv/hat_cfg_regs.sv
sv/hat_eval.sv
sv/hysteresis_alarm_trip_unit.sv
sim/testbench.sv
